// File: rtl/core/assert_macros.svh
// Assertion macros shared by the branch target buffer RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, c, r, a, b)
`define ASSERT_NEXT(lbl, c, r, a, b)
`endif

`endif

// File: rtl/core/ibtb_pkg.sv
// Package of the interleaved branch target buffer: item layout, mode codes,
// result and write-control types. No dependencies.
package ibtb_pkg;

  localparam int A_W = 48;
  localparam int MASK_W = 4;
  localparam int IN_W = 104;
  localparam int OUT_W = 56;

  localparam int IN_MODE_LSB = 0;
  localparam int IN_ADDR_LSB = 2;
  localparam int IN_BTGT_LSB = 50;
  localparam int IN_UNC_BIT = 98;
  localparam int IN_TAKEN_BIT = 99;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_QUERY  = 2'd0;
  localparam mode_t MODE_ADD    = 2'd1;
  localparam mode_t MODE_UPDATE = 2'd2;

  localparam logic [1:0] CNT_INIT = 2'd1;
  localparam logic [1:0] CNT_MAX  = 2'd3;
  localparam logic [1:0] CNT_MIN  = 2'd0;

  typedef struct packed {
    logic              hit;
    logic [A_W-1:0]    target;
    logic [MASK_W-1:0] vmask;
    logic              err;
  } result_t;

  typedef struct packed {
    logic ent_we;
    logic slot_we;
  } wr_t;

endpackage

// File: rtl/core/ibtb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ibtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/ibtb_dp.sv
// Read-modify-write datapath of the branch target buffer: hit check, slot
// scan, counter training and write-back data. Depends on ibtb_pkg.
module ibtb_dp #(
  parameter int EW = 48,
  parameter int BANK_BITS = 2,
  parameter int EB = 9
) (
  input  ibtb_pkg::mode_t                            mode,
  input  logic [EW-1:0]                              addr,
  input  logic [EW-1:0]                              btgt,
  input  logic                                       unc,
  input  logic                                       taken,
  input  logic [EW-BANK_BITS:0]                      ent_rdata,
  input  logic [(1 << BANK_BITS)*(EW+3)-1:0]         slot_rdata,
  output ibtb_pkg::result_t                          res,
  output ibtb_pkg::wr_t                              wr,
  output logic [EB-1:0]                              idx,
  output logic [EW-BANK_BITS:0]                      ent_wdata,
  output logic [(1 << BANK_BITS)*(EW+3)-1:0]         slot_wdata
);

  localparam int NB = 1 << BANK_BITS;
  localparam int TW = EW - BANK_BITS;
  localparam int SW = EW + 3;
  localparam int BW = (BANK_BITS > 0) ? BANK_BITS : 1;

  logic [TW-1:0]    tag;
  logic [EB+TW-1:0] tag_ext;
  logic [BW-1:0]    bank;
  logic             e_valid;
  logic [TW-1:0]    e_tag;
  logic [NB-1:0]    tk;
  logic             found;
  logic [BW-1:0]    first;
  logic [SW-1:0]    cur;
  logic [1:0]       cnt;
  logic [1:0]       cnt_next;

  always_comb begin
    tag = TW'(addr >> BANK_BITS);
    tag_ext = {{EB{1'b0}}, tag};
    idx = tag_ext[EB-1:0];
    bank = (BANK_BITS == 0) ? '0 : addr[BW-1:0];
    e_valid = ent_rdata[TW];
    e_tag = ent_rdata[TW-1:0];

    for (int i = 0; i < NB; i++) begin
      tk[i] = slot_rdata[i*SW+EW] | slot_rdata[i*SW+EW+2];
    end
    found = 1'b0;
    first = '0;
    for (int i = NB - 1; i >= 0; i--) begin
      if (tk[i]) begin
        found = 1'b1;
        first = BW'(i);
      end
    end

    cur = slot_rdata[bank*SW +: SW];
    cnt = cur[EW+2:EW+1];
    cnt_next = cnt;
    if (taken && cnt != ibtb_pkg::CNT_MAX) begin
      cnt_next = cnt + 2'd1;
    end else if (!taken && cnt != ibtb_pkg::CNT_MIN) begin
      cnt_next = cnt - 2'd1;
    end

    res = '0;
    wr = '0;
    ent_wdata = {1'b1, tag};
    slot_wdata = slot_rdata;

    unique case (mode)
      ibtb_pkg::MODE_QUERY: begin
        res.hit = e_valid && (e_tag == tag);
        res.target = ibtb_pkg::A_W'(EW'(addr + EW'(NB)));
        for (int j = 0; j < ibtb_pkg::MASK_W; j++) begin
          res.vmask[j] = (j < NB);
        end
        if (res.hit && found) begin
          res.target = ibtb_pkg::A_W'(slot_rdata[first*SW +: EW]);
          for (int j = 0; j < ibtb_pkg::MASK_W; j++) begin
            res.vmask[j] = (j < NB) && (BW'(j) <= first);
          end
        end
      end
      ibtb_pkg::MODE_ADD: begin
        wr.ent_we = 1'b1;
        wr.slot_we = 1'b1;
        slot_wdata[bank*SW +: SW] = {cnt, unc, btgt};
      end
      ibtb_pkg::MODE_UPDATE: begin
        if (!e_valid) begin
          res.err = 1'b1;
        end else begin
          wr.slot_we = 1'b1;
          slot_wdata[bank*SW +: SW] = {cnt_next, cur[EW:0]};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/core/interleaved_branch_target_buffer.sv
// Interleaved direct-mapped branch target buffer, top level.
// An accepted input item is read from both RAMs into the s1 stage, then its result item is
// registered in the output register; s1 holds while the output register is full and unread.
// A new input item is taken only while s1 is empty; s_tready drops while an item sits
// between its memory read and its write back to the same two RAMs.
// Reset: rst (synchronous) starts a clearing pass that writes every one of the
// 2**floor(log2(ENTRIES)) entries (512 by default); s_tready is low meanwhile.
`include "assert_macros.svh"

module interleaved_branch_target_buffer #(
  parameter int ENTRIES = 512,
  parameter int BANKS = 4,
  parameter int ADDR_BITS = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // mode[1:0], address[49:2], branch_target[97:50], is_unconditional[98],
  // taken[99], zero fill
  input  logic [ibtb_pkg::IN_W-1:0]     s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // hit[0], predicted_target[48:1], valid_mask[52:49], error[53], zero fill
  output logic [ibtb_pkg::OUT_W-1:0]    m_tdata
);

  localparam int BANK_BITS = $clog2(BANKS + 1) - 1;
  localparam int EB = $clog2(ENTRIES + 1) - 1;
  localparam int NE = 1 << EB;
  localparam int EW = (ADDR_BITS < ibtb_pkg::A_W) ? ADDR_BITS : ibtb_pkg::A_W;
  localparam int NB = 1 << BANK_BITS;
  localparam int TW = EW - BANK_BITS;
  localparam int SW = EW + 3;

  localparam logic [NB*SW-1:0] SLOT_INIT = {NB{{ibtb_pkg::CNT_INIT, 1'b0, {EW{1'b0}}}}};

  logic                 clearing;
  logic [EB-1:0]        clr_idx;
  logic                 s1_valid;
  ibtb_pkg::mode_t      s1_mode;
  logic [EW-1:0]        s1_addr;
  logic [EW-1:0]        s1_btgt;
  logic                 s1_unc;
  logic                 s1_taken;
  logic                 out_valid;
  ibtb_pkg::result_t    out_res;

  logic                 accept;
  logic                 out_free;
  logic                 s1_go;
  logic [EW-1:0]        in_addr;
  logic [TW-1:0]        in_tag;
  logic [EB+TW-1:0]     in_tag_ext;
  logic [EB-1:0]        rd_idx;

  logic [TW:0]          ent_rdata;
  logic [NB*SW-1:0]     slot_rdata;
  ibtb_pkg::result_t    dp_res;
  ibtb_pkg::wr_t        dp_wr;
  logic [EB-1:0]        dp_idx;
  logic [TW:0]          dp_ent_wdata;
  logic [NB*SW-1:0]     dp_slot_wdata;

  logic                 ent_we;
  logic                 slot_we;
  logic [EB-1:0]        waddr;
  logic [TW:0]          ent_wdata;
  logic [NB*SW-1:0]     slot_wdata;

  assign s_tready = !clearing && !s1_valid;
  assign accept = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign s1_go = s1_valid && out_free;

  assign in_addr = s_tdata[ibtb_pkg::IN_ADDR_LSB +: EW];
  assign in_tag = TW'(in_addr >> BANK_BITS);
  assign in_tag_ext = {{EB{1'b0}}, in_tag};
  assign rd_idx = in_tag_ext[EB-1:0];

  assign ent_we = clearing || (s1_go && dp_wr.ent_we);
  assign slot_we = clearing || (s1_go && dp_wr.slot_we);
  assign waddr = clearing ? clr_idx : dp_idx;
  assign ent_wdata = clearing ? '0 : dp_ent_wdata;
  assign slot_wdata = clearing ? SLOT_INIT : dp_slot_wdata;

  ibtb_ram #(
    .WIDTH(TW + 1),
    .DEPTH(NE)
  ) u_ent_ram (
    .clk  (clk),
    .we   (ent_we),
    .waddr(waddr),
    .wdata(ent_wdata),
    .re   (accept),
    .raddr(rd_idx),
    .rdata(ent_rdata)
  );

  ibtb_ram #(
    .WIDTH(NB * SW),
    .DEPTH(NE)
  ) u_slot_ram (
    .clk  (clk),
    .we   (slot_we),
    .waddr(waddr),
    .wdata(slot_wdata),
    .re   (accept),
    .raddr(rd_idx),
    .rdata(slot_rdata)
  );

  ibtb_dp #(
    .EW(EW),
    .BANK_BITS(BANK_BITS),
    .EB(EB)
  ) u_dp (
    .mode      (s1_mode),
    .addr      (s1_addr),
    .btgt      (s1_btgt),
    .unc       (s1_unc),
    .taken     (s1_taken),
    .ent_rdata (ent_rdata),
    .slot_rdata(slot_rdata),
    .res       (dp_res),
    .wr        (dp_wr),
    .idx       (dp_idx),
    .ent_wdata (dp_ent_wdata),
    .slot_wdata(dp_slot_wdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == EB'(NE - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode <= s_tdata[ibtb_pkg::IN_MODE_LSB +: 2];
      s1_addr <= in_addr;
      s1_btgt <= s_tdata[ibtb_pkg::IN_BTGT_LSB +: EW];
      s1_unc <= s_tdata[ibtb_pkg::IN_UNC_BIT];
      s1_taken <= s_tdata[ibtb_pkg::IN_TAKEN_BIT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_res <= dp_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {2'b00, out_res.err, out_res.vmask, out_res.target, out_res.hit};

  `ASSERT_NEXT(a_accept_s1, clk, rst, accept, s1_valid)
  `ASSERT_NEXT(a_go_out, clk, rst, s1_go, m_tvalid)
  `ASSERT_NEXT(a_stall_hold, clk, rst, s1_valid && !out_free, s1_valid && $stable(s1_addr))
  `ASSERT_IMPLY(a_clear_idle, clk, rst, clearing, !s1_valid && !m_tvalid)

endmodule

// File: sim/ibtb_response_checker.sv
// Scoreboard for the interleaved branch target buffer: mirrors the table, predicts
// each result item from the accepted input items and compares it on arrival.
// Depends on ibtb_pkg for the item layout, the mode codes and the result type.
module ibtb_response_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [ibtb_pkg::IN_W-1:0]  s_tdata,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [ibtb_pkg::OUT_W-1:0] m_tdata,
  output int                         fail_count,
  output int                         pending,
  output int                         result_count,
  output int                         hit_count,
  output int                         update_error_count
);
  import ibtb_pkg::*;

  localparam int BANK_BITS = 2;
  localparam int IDX_BITS = 9;
  localparam int NB = 1 << BANK_BITS;
  localparam int NE = 1 << IDX_BITS;
  localparam int TAG_W = A_W - BANK_BITS;

  logic             ent_valid [NE];
  logic [TAG_W-1:0] ent_tag   [NE];
  logic [A_W-1:0]   slot_tgt  [NE*NB];
  logic             slot_unc  [NE*NB];
  logic [1:0]       slot_cnt  [NE*NB];

  result_t btb_responses_due [$];

  function automatic result_t btb_step(input logic [IN_W-1:0] d);
    mode_t            mode;
    logic [A_W-1:0]   addr;
    logic [A_W-1:0]   btgt;
    logic             unc;
    logic             taken;
    logic [TAG_W-1:0] tag;
    logic [IDX_BITS-1:0] idx;
    int               base;
    int               slot;
    logic             found;
    result_t          r;
    mode  = d[IN_MODE_LSB +: 2];
    addr  = d[IN_ADDR_LSB +: A_W];
    btgt  = d[IN_BTGT_LSB +: A_W];
    unc   = d[IN_UNC_BIT];
    taken = d[IN_TAKEN_BIT];
    tag   = addr[A_W-1:BANK_BITS];
    idx   = tag[IDX_BITS-1:0];
    base  = int'(idx) * NB;
    slot  = base + int'(addr[BANK_BITS-1:0]);
    r = '0;
    case (mode)
      MODE_QUERY: begin
        r.target = addr + A_W'(NB);
        r.vmask = '1;
        if (ent_valid[idx] && ent_tag[idx] == tag) begin
          r.hit = 1'b1;
          r.vmask = '0;
          found = 1'b0;
          for (int i = 0; i < NB; i++) begin
            if (!found) begin
              r.vmask[i] = 1'b1;
              if (slot_unc[base+i] || slot_cnt[base+i] >= 2'd2) begin
                found = 1'b1;
                r.target = slot_tgt[base+i];
              end
            end
          end
        end
      end
      MODE_ADD: begin
        ent_valid[idx] = 1'b1;
        ent_tag[idx] = tag;
        slot_tgt[slot] = btgt;
        slot_unc[slot] = unc;
      end
      MODE_UPDATE: begin
        if (!ent_valid[idx]) begin
          r.err = 1'b1;
        end else if (taken) begin
          if (slot_cnt[slot] != CNT_MAX) slot_cnt[slot]++;
        end else if (slot_cnt[slot] != CNT_MIN) begin
          slot_cnt[slot]--;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [A_W-1:0] want,
                               input logic [A_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t due;
    if (rst) begin
      for (int e = 0; e < NE; e++) begin
        ent_valid[e] = 1'b0;
        ent_tag[e] = '0;
      end
      for (int s = 0; s < NE*NB; s++) begin
        slot_tgt[s] = '0;
        slot_unc[s] = 1'b0;
        slot_cnt[s] = CNT_INIT;
      end
      btb_responses_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        result_count++;
        if (btb_responses_due.size() == 0) begin
          $error("result item with nothing outstanding: m_tdata=%h", m_tdata);
          fail_count++;
        end else begin
          due = btb_responses_due.pop_front();
          compare_field("hit", due.hit, m_tdata[0]);
          compare_field("predicted_target", due.target, m_tdata[48:1]);
          compare_field("valid_mask", due.vmask, m_tdata[52:49]);
          compare_field("error", due.err, m_tdata[53]);
          if (m_tdata[0] === 1'b1) hit_count++;
          if (m_tdata[53] === 1'b1) update_error_count++;
        end
      end
      if (s_tvalid && s_tready) btb_responses_due.push_back(btb_step(s_tdata));
    end
    pending = btb_responses_due.size();
  end

endmodule

// File: sim/tb_interleaved_branch_target_buffer.sv
// Testbench top for the interleaved branch target buffer: directed lookups, adds
// and counter training, then random phases with sender gaps and receiver stalls.
// Depends on ibtb_pkg, the block and ibtb_response_checker.
module tb_interleaved_branch_target_buffer;
  import ibtb_pkg::*;

  localparam mode_t MODE_NONE = 2'd3;
  localparam int PHASE_ITEMS = 425;
  localparam int HOLD_CYCLES = 400;
  localparam int TAG_LSB = 11;
  localparam logic [A_W-1:0] ADDR_A = 48'h1234_5678_9abc;
  localparam logic [A_W-1:0] ADDR_B = 48'h9234_5678_9abc;
  localparam logic [A_W-1:0] ADDR_TOP = '1;

  logic            clk;
  logic            rst;
  logic            s_tvalid;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata;
  logic            m_tvalid;
  logic            m_tready;
  logic [OUT_W-1:0] m_tdata;

  int fail_count;
  int pending;
  int result_count;
  int hit_count;
  int update_error_count;
  int send_idle_pct;
  int ready_stall_pct;
  int hold_requests;
  int mode_count [4];
  logic [A_W-1:0] hot_addr [16];

  interleaved_branch_target_buffer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  ibtb_response_checker i_scoreboard (
    .clk                (clk),
    .rst                (rst),
    .s_tvalid           (s_tvalid),
    .s_tready           (s_tready),
    .s_tdata            (s_tdata),
    .m_tvalid           (m_tvalid),
    .m_tready           (m_tready),
    .m_tdata            (m_tdata),
    .fail_count         (fail_count),
    .pending            (pending),
    .result_count       (result_count),
    .hit_count          (hit_count),
    .update_error_count (update_error_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    #4_000_000;
    $display("timeout: run did not complete");
    $display("status: fail");
    $finish;
  end

  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= ready_stall_pct);
      end
    end
  end

  function automatic logic [IN_W-1:0] pack_item(input mode_t mode, input logic [A_W-1:0] addr,
                                                input logic [A_W-1:0] btgt,
                                                input logic unc, input logic taken);
    logic [IN_W-1:0] d;
    d = '0;
    d[IN_MODE_LSB +: 2] = mode;
    d[IN_ADDR_LSB +: A_W] = addr;
    d[IN_BTGT_LSB +: A_W] = btgt;
    d[IN_UNC_BIT] = unc;
    d[IN_TAKEN_BIT] = taken;
    return d;
  endfunction

  function automatic logic [A_W-1:0] rand_wide();
    return A_W'({$urandom, $urandom});
  endfunction

  function automatic logic [A_W-1:0] rand_addr();
    logic [A_W-1:0] a;
    logic [A_W-1:0] w;
    int pick;
    a = hot_addr[$urandom_range(15)];
    w = rand_wide();
    pick = $urandom_range(99);
    if (pick < 15) a = w;
    else if (pick < 30) a[A_W-1:TAG_LSB] = w[A_W-1:TAG_LSB];
    a[1:0] = 2'($urandom);
    return a;
  endfunction

  task automatic issue(input logic [IN_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    mode_count[d[IN_MODE_LSB +: 2]]++;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic issue_random();
    int pick;
    mode_t mode;
    pick = $urandom_range(99);
    if (pick < 40) mode = MODE_QUERY;
    else if (pick < 63) mode = MODE_ADD;
    else if (pick < 96) mode = MODE_UPDATE;
    else mode = MODE_NONE;
    issue(pack_item(mode, rand_addr(), rand_wide(), $urandom_range(3) == 0,
                    $urandom_range(9) < 6));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  initial begin : stimulus
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    send_idle_pct = 0;
    ready_stall_pct = 0;
    hold_requests = 0;
    hot_addr[0] = '0;
    hot_addr[1] = '1;
    for (int k = 2; k < 16; k++) hot_addr[k] = rand_wide();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    issue(pack_item(MODE_QUERY, '0, '0, 1'b0, 1'b0));
    issue(pack_item(MODE_QUERY, ADDR_TOP, '0, 1'b0, 1'b0));
    issue(pack_item(MODE_UPDATE, '0, '0, 1'b0, 1'b1));
    issue(pack_item(MODE_ADD, ADDR_A, '1, 1'b0, 1'b0));
    issue(pack_item(MODE_QUERY, ADDR_A, '0, 1'b0, 1'b0));
    issue(pack_item(MODE_UPDATE, ADDR_A, '0, 1'b0, 1'b1));
    issue(pack_item(MODE_QUERY, ADDR_A | 48'd1, '0, 1'b0, 1'b0));
    issue(pack_item(MODE_ADD, ADDR_A | 48'd2, '0, 1'b1, 1'b0));
    repeat (3) issue(pack_item(MODE_UPDATE, ADDR_A, '0, 1'b0, 1'b0));
    issue(pack_item(MODE_QUERY, ADDR_A, '0, 1'b0, 1'b0));
    repeat (3) issue(pack_item(MODE_UPDATE, ADDR_A | 48'd3, '0, 1'b0, 1'b1));
    issue(pack_item(MODE_QUERY, ADDR_B, '0, 1'b0, 1'b0));
    issue(pack_item(MODE_ADD, ADDR_B | 48'd1, 48'd1, 1'b1, 1'b0));
    issue(pack_item(MODE_QUERY, ADDR_A, '0, 1'b0, 1'b0));
    issue(pack_item(MODE_QUERY, ADDR_B, '0, 1'b0, 1'b0));
    issue(pack_item(MODE_ADD, ADDR_TOP, '1, 1'b1, 1'b1));
    issue(pack_item(MODE_QUERY, ADDR_TOP, '0, 1'b0, 1'b0));
    issue(pack_item(MODE_NONE, ADDR_TOP, '1, 1'b1, 1'b1));
    issue(pack_item(MODE_UPDATE, '0, '0, 1'b0, 1'b0));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
        1: begin send_idle_pct = 75; ready_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  ready_stall_pct = 75; end
        default: begin send_idle_pct = 29; ready_stall_pct = 29; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 100) hold_requests++;
        issue_random();
      end
      drain();
    end

    repeat (8) @(posedge clk);
    $display("covered %0d queries, %0d adds, %0d updates and %0d items of the unused mode",
             mode_count[MODE_QUERY], mode_count[MODE_ADD], mode_count[MODE_UPDATE],
             mode_count[MODE_NONE]);
    $display("checked %0d results: %0d hits, %0d updates on empty entries",
             result_count, hit_count, update_error_count);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
